/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge, masked while reset is applied
`define FSNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included
`define FSNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hw/rtl/fsne_pkg.sv */
// Shared types and constants of the sideband NAL encoder
package fsne_pkg;

  localparam int FIB_TERMS   = 12;
  localparam int UPPER_TERMS = 6;
  localparam int CODE_W      = FIB_TERMS + 1;
  localparam int PACK_W      = 8 + CODE_W;

  localparam logic [8:0] FIB_TABLE [FIB_TERMS] = '{
    9'd1, 9'd2, 9'd3, 9'd5, 9'd8, 9'd13, 9'd21, 9'd34, 9'd55, 9'd89, 9'd144, 9'd233
  };

  localparam logic [7:0] START_CODE [3] = '{8'h00, 8'h00, 8'h01};
  localparam logic [7:0] STUFF_BYTE     = 8'h03;
  localparam logic [7:0] STUFF_LIMIT    = 8'h04;
  localparam logic [7:0] NO_ZERO        = 8'hFF;
  localparam logic [7:0] NAL_TYPE_RESET = 8'd24;
  localparam logic [1:0] HDR_LAST       = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef enum logic {
    ENT_HDR = 1'b0,
    ENT_PAY = 1'b1
  } ent_kind_t;

  // one queued job: a header, or one or two payload bytes
  typedef struct packed {
    ent_kind_t  kind;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } q_entry_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
  } q_stat_t;

endpackage

/* hw/rtl/fsne_front.sv */
// Front end: command intake, zigzag map, Fibonacci code and bit packing
module fsne_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_value,
  output logic               push_valid,
  input  logic               push_ready,
  output fsne_pkg::q_entry_t push_entry
);
  import fsne_pkg::*;

  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [8:0]  s1_mapped_r;
  logic        s2_valid_r;
  cmd_t        s2_cmd_r;
  logic [4:0]  s2_rem_r;
  logic [UPPER_TERMS-1:0] s2_hi_r;
  logic [7:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;

  logic [7:0]  neg_mag;
  logic [8:0]  mapped_in;
  logic [8:0]  rem1;
  logic [UPPER_TERMS-1:0] hi1;
  logic [4:0]  rem2;
  logic [FIB_TERMS-UPPER_TERMS-1:0] lo2;
  logic [FIB_TERMS-1:0] bits;
  logic [3:0]  top;
  logic [CODE_W-1:0] code;
  logic [3:0]  nbits;
  logic [4:0]  total;
  logic [PACK_W-1:0] word;
  logic        need_push;
  logic        s2_go, s2_free, s1_free;

  // zigzag: negatives to odd, positives to even, zero to one
  always_comb begin
    neg_mag = 8'(~in_value + 8'd1);
    if (in_value[7]) begin
      mapped_in = {neg_mag, 1'b1};
    end else if (in_value == 8'd0) begin
      mapped_in = 9'd1;
    end else begin
      mapped_in = {in_value, 1'b0};
    end
  end

  // greedy over the six largest terms
  always_comb begin
    rem1 = s1_mapped_r;
    hi1  = '0;
    for (int k = FIB_TERMS - 1; k >= FIB_TERMS - UPPER_TERMS; k--) begin
      if (rem1 >= FIB_TABLE[k]) begin
        hi1[k - (FIB_TERMS - UPPER_TERMS)] = 1'b1;
        rem1 = rem1 - FIB_TABLE[k];
      end
    end
  end

  // remaining terms, code assembly and merge with leftover bits
  always_comb begin
    rem2 = s2_rem_r;
    lo2  = '0;
    for (int k = FIB_TERMS - UPPER_TERMS - 1; k >= 0; k--) begin
      if (rem2 >= FIB_TABLE[k][4:0]) begin
        lo2[k] = 1'b1;
        rem2 = rem2 - FIB_TABLE[k][4:0];
      end
    end
    bits = {s2_hi_r, lo2};
    top  = '0;
    for (int k = 0; k < FIB_TERMS; k++) begin
      if (bits[k]) begin
        top = 4'(k);
      end
    end
    code = '0;
    for (int k = 0; k < FIB_TERMS; k++) begin
      code[CODE_W-1-k] = bits[k];
    end
    if (top == 4'(FIB_TERMS - 1)) begin
      nbits = 4'(FIB_TERMS);
    end else begin
      code  = code | (CODE_W'(1) << (4'(CODE_W - 2) - top));
      nbits = top + 4'd2;
    end
    total = {1'b0, nbits} + {2'b00, pend_cnt_r};
    word  = {pend_bits_r, CODE_W'(0)} | ({code, 8'h00} >> pend_cnt_r);
  end

  always_comb begin
    need_push     = 1'b0;
    push_entry    = '{kind: ENT_HDR, two: 1'b0, b0: 8'h00, b1: 8'h00};
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    case (s2_cmd_r)
      CMD_START: begin
        need_push     = 1'b1;
        pend_bits_nxt = 8'h00;
        pend_cnt_nxt  = 3'd0;
      end
      CMD_WRITE: begin
        need_push       = (total[4:3] != 2'd0);
        push_entry.kind = ENT_PAY;
        push_entry.two  = total[4];
        push_entry.b0   = word[PACK_W-1 -: 8];
        push_entry.b1   = word[PACK_W-9 -: 8];
        pend_cnt_nxt    = total[2:0];
        case (total[4:3])
          2'd0:    pend_bits_nxt = word[PACK_W-1 -: 8];
          2'd1:    pend_bits_nxt = word[PACK_W-9 -: 8];
          default: pend_bits_nxt = {word[PACK_W-17:0], 3'b000};
        endcase
      end
      CMD_FLUSH: begin
        need_push       = (pend_cnt_r != 3'd0);
        push_entry.kind = ENT_PAY;
        push_entry.b0   = pend_bits_r;
        pend_bits_nxt   = 8'h00;
        pend_cnt_nxt    = 3'd0;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  assign push_valid = s2_valid_r && need_push;
  assign s2_go      = s2_valid_r && (!need_push || push_ready);
  assign s2_free    = !s2_valid_r || s2_go;
  assign s1_free    = !s1_valid_r || s2_free;
  assign in_ready   = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      pend_bits_r <= 8'h00;
      pend_cnt_r  <= 3'd0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s2_go) begin
        pend_bits_r <= pend_bits_nxt;
        pend_cnt_r  <= pend_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_cmd_r    <= cmd_t'(in_command);
      s1_mapped_r <= mapped_in;
    end
    if (s2_free && s1_valid_r) begin
      s2_cmd_r <= s1_cmd_r;
      s2_rem_r <= rem1[4:0];
      s2_hi_r  <= hi1;
    end
  end

endmodule

/* hw/rtl/fsne_queue.sv */
// Short job queue between front and back end
module fsne_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fsne_pkg::q_entry_t push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fsne_pkg::q_entry_t pop_entry,
  output fsne_pkg::q_stat_t  stat
);
  import fsne_pkg::*;

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* hw/rtl/fsne_back.sv */
// Back end: header and payload byte emission with emulation prevention
module fsne_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         nal_type,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  fsne_pkg::q_entry_t pop_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_data,
  output logic               out_last
);
  import fsne_pkg::*;

  logic       cur_valid_r;
  q_entry_t   cur_r;
  logic [1:0] idx_r;
  logic       stuffed_r;
  logic [7:0] hist_mid_r, hist_new_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  logic       slot_free, emit, need_stuff, final_byte;
  logic [7:0] pay_byte, byte_nxt;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = cur_valid_r && slot_free;
  assign pay_byte  = idx_r[0] ? cur_r.b1 : cur_r.b0;
  // two zero bytes already out and a small byte next: stuff first
  assign need_stuff = (cur_r.kind == ENT_PAY) && !stuffed_r &&
                      (hist_mid_r == 8'h00) && (hist_new_r == 8'h00) &&
                      (pay_byte < STUFF_LIMIT);

  always_comb begin
    if (cur_r.kind == ENT_HDR) begin
      byte_nxt   = (idx_r == HDR_LAST) ? nal_type : START_CODE[idx_r];
      final_byte = (idx_r == HDR_LAST);
    end else if (need_stuff) begin
      byte_nxt   = STUFF_BYTE;
      final_byte = 1'b0;
    end else begin
      byte_nxt   = pay_byte;
      final_byte = (idx_r[0] == cur_r.two);
    end
  end

  assign pop_ready = !cur_valid_r || (emit && final_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      stuffed_r   <= 1'b0;
      hist_mid_r  <= NO_ZERO;
      hist_new_r  <= NO_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        if (cur_r.kind == ENT_HDR) begin
          if (final_byte) begin
            hist_new_r <= NO_ZERO;
          end
        end else if (need_stuff) begin
          stuffed_r <= 1'b1;
        end else begin
          hist_mid_r <= stuffed_r ? NO_ZERO : hist_new_r;
          hist_new_r <= pay_byte;
          stuffed_r  <= 1'b0;
        end
      end
      if (pop_ready && pop_valid) begin
        cur_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (emit && !need_stuff) begin
        idx_r <= final_byte ? 2'd0 : idx_r + 2'd1;
        if (final_byte) begin
          cur_valid_r <= 1'b0;
        end
      end
      if (slot_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      cur_r <= pop_entry;
    end
    if (emit) begin
      out_data_r <= byte_nxt;
      out_last_r <= final_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

/* hw/rtl/fibonacci_sideband_nal_encoder.sv */
// Top level of the Fibonacci-coded sideband NAL unit encoder
//
// Input stream: one command per transfer (start unit, encode one signed byte,
// flush). Output stream: NAL unit bytes, emulation-prevention bytes included;
// tlast marks the final byte caused by a command. Commands that cause no byte
// (a short code, a flush with nothing pending, an unused code) emit nothing.
// cfg_wr_en/cfg_wr_data set the fourth header byte, 24 after reset; write it
// only while the block is idle.
// Throughput: the output register moves one byte per cycle while out_tready
// is high; a start emits 4 bytes, a value 0 to 3 bytes. The front end takes
// one command per cycle while in_tready is high; a 4-entry job queue between
// front and back end absorbs the difference.
// Reset clears the pipeline, the queue, the leftover code bits and the byte
// history. When the receiver stalls, the output byte holds; the queue and the
// two front stages fill, then in_tready drops.
`include "assert_macros.svh"

module fibonacci_sideband_nal_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [1:0] command, [9:2] value, [15:10] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data  // [7:0] sideband_nal_type
);
  import fsne_pkg::*;

  logic       [7:0] nal_type_r;
  logic             q_push_valid, q_push_ready;
  q_entry_t         q_push_entry;
  logic             q_pop_valid, q_pop_ready;
  q_entry_t         q_pop_entry;
  q_stat_t          q_stat;
  logic             q_push_only;
  logic [Q_CW-1:0]  q_count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nal_type_r <= NAL_TYPE_RESET;
    end else if (cfg_wr_en) begin
      nal_type_r <= cfg_wr_data;
    end
  end

  fsne_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_command (in_tdata[1:0]),
    .in_value   (in_tdata[9:2]),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_entry (q_push_entry)
  );

  fsne_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_entry (q_push_entry),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_entry  (q_pop_entry),
    .stat       (q_stat)
  );

  fsne_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nal_type  (nal_type_r),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_entry (q_pop_entry),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  assign q_push_only = q_push_valid && q_push_ready && !(q_pop_valid && q_pop_ready);
  assign q_count_inc = q_stat.count + 1'b1;

  `FSNE_ASSERT_ALWAYS(a_out_idle_after_reset, !rst_n |=> !out_tvalid, "output valid after reset")
  `FSNE_ASSERT(a_queue_bound, q_stat.count <= Q_CW'(Q_DEPTH), "job queue overfilled")
  `FSNE_ASSERT(a_queue_push, q_push_only |=> q_stat.count == $past(q_count_inc), "queue push lost")

endmodule

/* tb/tb_fibonacci_sideband_nal_encoder.sv */
// Self-checking testbench for the Fibonacci-coded sideband NAL unit encoder
module tb_fibonacci_sideband_nal_encoder;
  import fsne_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 12;

  // Expected byte stream, worked out per accepted command
  class nal_scoreboard;
    localparam int unsigned FIB [12] = '{1, 2, 3, 5, 8, 13, 21, 34, 55, 89, 144, 233};

    logic [7:0]  exp_byte_q[$];
    bit          exp_last_q[$];
    logic [7:0]  nal_type;
    logic [7:0]  hist_old, hist_mid, hist_new;
    logic [7:0]  pend_bits;
    int unsigned pend_cnt;
    int unsigned errors, n_cmds, n_bytes, n_stuffed;

    function new();
      nal_type  = NAL_TYPE_RESET;
      hist_old  = NO_ZERO;
      hist_mid  = NO_ZERO;
      hist_new  = NO_ZERO;
      pend_bits = '0;
      pend_cnt  = 0;
      errors    = 0;
      n_cmds    = 0;
      n_bytes   = 0;
      n_stuffed = 0;
    endfunction

    function int unsigned pending();
      return exp_byte_q.size();
    endfunction

    function void put_raw(logic [7:0] b);
      exp_byte_q.push_back(b);
      exp_last_q.push_back(1'b0);
    endfunction

    function void put_payload(logic [7:0] b);
      hist_old = hist_mid;
      hist_mid = hist_new;
      hist_new = b;
      if (hist_old == 8'h00 && hist_mid == 8'h00 && hist_new < STUFF_LIMIT) begin
        put_raw(STUFF_BYTE);
        hist_mid = NO_ZERO;
        n_stuffed++;
      end
      put_raw(b);
    endfunction

    function void note_command(logic [1:0] cmd, logic [7:0] val);
      int unsigned first, mapped, nbits;
      int          top, k;
      logic [31:0] word;
      first = exp_byte_q.size();
      n_cmds++;
      if (cmd == CMD_START) begin
        put_raw(8'h00);
        put_raw(8'h00);
        put_raw(8'h01);
        put_raw(nal_type);
        hist_new  = NO_ZERO;
        pend_bits = '0;
        pend_cnt  = 0;
      end else if (cmd == CMD_WRITE) begin
        // zigzag: negative to odd, zero to one, positive to even
        if (val[7])
          mapped = 2 * (256 - val) + 1;
        else if (val == 8'h00)
          mapped = 1;
        else
          mapped = 2 * val;
        top = 11;
        while (top > 0 && FIB[top] > mapped)
          top--;
        // the longest code has no room for the terminating one
        if (top == 11) begin
          word  = '0;
          nbits = top + 1;
        end else begin
          word  = 32'h8000_0000;
          nbits = top + 2;
        end
        for (k = top; k >= 0; k--) begin
          word = word >> 1;
          if (FIB[k] <= mapped) begin
            word[31] = 1'b1;
            mapped   = mapped - FIB[k];
          end
        end
        nbits = nbits + pend_cnt;
        word  = (word >> pend_cnt) | {pend_bits, 24'h0};
        while (nbits >= 8) begin
          put_payload(word[31:24]);
          nbits = nbits - 8;
          word  = word << 8;
        end
        pend_cnt  = nbits & 7;
        pend_bits = word[31:24];
      end else if (cmd == CMD_FLUSH) begin
        if (pend_cnt > 0)
          put_payload(pend_bits);
        pend_bits = '0;
        pend_cnt  = 0;
      end
      if (exp_byte_q.size() > first)
        exp_last_q[exp_last_q.size() - 1] = 1'b1;
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      logic [7:0] eb;
      bit         el;
      if (exp_byte_q.size() == 0) begin
        $error("out_tdata: transfer %02h with nothing expected", b);
        errors++;
        return;
      end
      eb = exp_byte_q.pop_front();
      el = exp_last_q.pop_front();
      n_bytes++;
      if (b !== eb) begin
        $error("out_byte: expected %02h, got %02h", eb, b);
        errors++;
      end
      if (last !== el) begin
        $error("last: expected %0b, got %0b", el, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  nal_scoreboard sb = new();

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned hold_len   = 0;

  // directed commands, {value, command}
  localparam logic [9:0] DIRECTED [25] = '{
    {8'hAA, CMD_START}, {8'h00, CMD_WRITE}, {8'h01, CMD_WRITE}, {8'h7F, CMD_WRITE},
    {8'h80, CMD_WRITE}, {8'hFF, CMD_WRITE}, {8'h81, CMD_WRITE}, {8'h8C, CMD_WRITE},
    {8'h55, CMD_FLUSH}, {8'hFF, CMD_FLUSH}, {8'h55, CMD_UNUSED}, {8'h48, CMD_WRITE},
    {8'h8C, CMD_WRITE}, {8'h00, CMD_START}, {8'h40, CMD_WRITE}, {8'hC0, CMD_WRITE},
    {8'h00, CMD_FLUSH}, {8'h80, CMD_WRITE}, {8'h7F, CMD_WRITE}, {8'h8C, CMD_WRITE},
    {8'h8C, CMD_WRITE}, {8'h01, CMD_FLUSH}, {8'hFF, CMD_START}, {8'h00, CMD_FLUSH},
    {8'hD4, CMD_WRITE}
  };

  fibonacci_sideband_nal_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[fibonacci_sideband_nal_encoder] ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_byte(out_tdata, out_tlast);
  end

  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      4:       return 8'h8C;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] val);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, val);
  endtask

  // mostly whole units (start, values, flush), some stray commands
  task automatic send_random(input int unsigned count);
    int unsigned done, nwr;
    logic [1:0]  cmd;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 4) != 0) begin
        send_cmd(CMD_START, 8'($urandom_range(0, 255)));
        nwr = $urandom_range(1, 10);
        repeat (nwr) send_cmd(CMD_WRITE, pick_value());
        done += nwr + 1;
        if ($urandom_range(0, 5) != 0) begin
          send_cmd(CMD_FLUSH, 8'($urandom_range(0, 255)));
          done++;
        end
      end else begin
        cmd = 2'($urandom_range(0, 3));
        send_cmd(cmd, pick_value());
        if (cmd != CMD_UNUSED)
          done++;
      end
    end
  endtask

  // header type may only change once the block has gone quiet
  task automatic set_nal_type(input logic [7:0] t);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.nal_type = t;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_cmd(DIRECTED[i][1:0], DIRECTED[i][9:2]);

    set_nal_type(8'h00);
    send_random(100);

    // long receiver hold-off while the sender keeps pushing
    set_nal_type(8'hFF);
    hold_len   = 300;
    hold_req   = 1'b1;
    tx_idle_en = 1'b0;
    send_random(40);
    tx_idle_en = 1'b1;
    send_random(60);

    set_nal_type(8'($urandom_range(1, 254)));
    send_random(100);

    // closing stretch at full rate
    set_nal_type(8'h5A);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(80);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d commands (units, strays, unused code) and %0d output bytes,",
             sb.n_cmds, sb.n_bytes);
    $display("header types 24, 0, 255 and two others, %0d stuffing bytes predicted.",
             sb.n_stuffed);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[fibonacci_sideband_nal_encoder] OK");
    else
      $display("[fibonacci_sideband_nal_encoder] ERROR");
    $finish;
  end

endmodule
